// File: rtl/rra_pkg.sv
// Shared types, constants and a helper function for the register allocator.
package rra_pkg;

  // Register file geometry; the index field width fixes the register count
  localparam int ADDR_W   = 5;
  localparam int NUM_REGS = 1 << ADDR_W;
  localparam int CNT_W    = 16;
  localparam int RCNT_W   = CNT_W + 1;
  localparam int MODE_W   = 3;
  localparam int STAT_W   = 2;

  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [RCNT_W-1:0] RCNT_RSV  = '1;   // -1 reported for a reserved register

  typedef enum logic [MODE_W-1:0] {
    MODE_ACQUIRE = 3'd0,
    MODE_ADDREF  = 3'd1,
    MODE_MIRROR  = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_QUERY   = 3'd4,
    MODE_FIND    = 3'd5
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NONE_FREE = 2'd1,
    STAT_NOT_HELD  = 2'd2,
    STAT_SATURATED = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Index of the lowest set bit (0 when none is set)
  function automatic logic [ADDR_W-1:0] lowest_set(input logic [NUM_REGS-1:0] v);
    logic [NUM_REGS-1:0] onehot;
    logic [ADDR_W-1:0]   idx;
    onehot = v & (~v + NUM_REGS'(1));
    idx    = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (onehot[i]) begin
        idx = idx | ADDR_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/rra_in_if.sv
// Valid/ready channel carrying one allocator request transaction.
interface rra_in_if;
  logic                      valid;
  logic                      ready;
  logic [rra_pkg::MODE_W-1:0] mode;
  logic [rra_pkg::ADDR_W-1:0] reg_addr;

  modport source (output valid, output mode, output reg_addr, input ready);
  modport sink   (input valid, input mode, input reg_addr, output ready);
endinterface

// File: rtl/rra_out_if.sv
// Valid/ready channel carrying one allocator result transaction.
interface rra_out_if;
  logic                               valid;
  logic                               ready;
  logic [rra_pkg::ADDR_W-1:0]         reg_index;
  logic                               found;
  logic                               became_free;
  logic signed [rra_pkg::RCNT_W-1:0]  ref_count;
  logic [rra_pkg::STAT_W-1:0]         status;

  modport source (output valid, output reg_index, output found, output became_free,
                  output ref_count, output status, input ready);
  modport sink   (input valid, input reg_index, input found, input became_free,
                  input ref_count, input status, output ready);
endinterface

// File: rtl/refcounted_register_allocator.sv
// Reference-counted register allocator: count memory, held bitmap and a two-step sequencer.
//
// Each request runs in two steps: in the accept cycle the held bitmap and the
// reserved mask go through a lowest-set-bit encoder to pick the target register
// for acquire and find (else the request address) and the count memory is read
// at it; in the second step the shared increment/decrement unit updates the
// count, the memory is written back and the result enters the output register.
// No new request is accepted before that step commits; the input side stays
// ready while a result waits in the output register, and the second step
// stalls only if the previous result has not yet been taken. Counts live in a
// 32 x 16 memory without reset; a held bit per register (cleared by reset)
// marks a nonzero count, and a register that is not held reads as zero, so no
// clearing pass is needed. The reserved mask may be written only while idle.
module refcounted_register_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rra_pkg::NUM_REGS-1:0] cfg_wdata,
  rra_in_if.sink                       in_ch,
  rra_out_if.source                    out_ch
);
  import rra_pkg::*;

  // State and configuration
  state_t               state_r, state_nxt;
  logic [NUM_REGS-1:0]  rsv_mask_r;
  logic [NUM_REGS-1:0]  held_r;
  logic [CNT_W-1:0]     cnt_mem [NUM_REGS];

  // Request captured at accept
  mode_t                mode_r;
  logic [ADDR_W-1:0]    idx_r;
  logic                 hit_r;
  logic                 rsv_r;
  logic                 held_bit_r;
  logic [CNT_W-1:0]     rd_data_r;

  // Output register
  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_index_r;
  logic                 out_found_r;
  logic                 out_freed_r;
  logic [RCNT_W-1:0]    out_count_r;
  status_t              out_status_r;

  logic                 accept;
  logic                 out_free;
  logic                 commit;

  // Target selection in the accept cycle
  mode_t                in_mode;
  logic [NUM_REGS-1:0]  vacant_vec;
  logic [NUM_REGS-1:0]  held_vec;
  logic [NUM_REGS-1:0]  search_vec;
  logic [ADDR_W-1:0]    sel_idx;
  logic                 sel_hit;

  // Second-step results
  logic [CNT_W-1:0]     cur_cnt;
  logic [CNT_W-1:0]     alu_out;
  logic                 alu_dec;
  logic                 wr_en;
  logic [CNT_W-1:0]     wr_data;
  logic                 held_set;
  logic                 held_clr;
  logic [ADDR_W-1:0]    res_index;
  logic                 res_found;
  logic                 res_freed;
  logic [RCNT_W-1:0]    res_count;
  status_t              res_status;

  assign in_mode  = mode_t'(in_ch.mode);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign commit   = (state_r == ST_EXEC) && out_free;

  // Vacancy and held-search vectors, then the lowest-set-bit encoder
  always_comb begin
    vacant_vec = ~held_r & ~rsv_mask_r;
    for (int i = 0; i < NUM_REGS; i++) begin
      held_vec[i] = held_r[i] && !rsv_mask_r[i] && (ADDR_W'(i) >= in_ch.reg_addr);
    end
    search_vec = (in_mode == MODE_FIND) ? held_vec : vacant_vec;
    sel_hit    = |search_vec;
    if (in_mode == MODE_ACQUIRE || in_mode == MODE_FIND) begin
      sel_idx = lowest_set(search_vec);
    end else begin
      sel_idx = in_ch.reg_addr;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and the second-step operation
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    cur_cnt     = held_bit_r ? rd_data_r : '0;
    alu_dec     = (mode_r == MODE_RELEASE);
    alu_out     = alu_dec ? (cur_cnt - CNT_W'(1)) : (cur_cnt + CNT_W'(1));

    wr_en      = 1'b0;
    wr_data    = alu_out;
    held_set   = 1'b0;
    held_clr   = 1'b0;
    res_index  = '0;
    res_found  = 1'b0;
    res_freed  = 1'b0;
    res_count  = '0;
    res_status = STAT_OK;

    unique case (mode_r)
      MODE_ACQUIRE: begin
        if (hit_r) begin
          wr_en     = 1'b1;
          wr_data   = CNT_W'(1);
          held_set  = 1'b1;
          res_index = idx_r;
          res_found = 1'b1;
          res_count = RCNT_W'(1);
        end else begin
          res_status = STAT_NONE_FREE;
        end
      end
      MODE_ADDREF, MODE_MIRROR: begin
        res_index = idx_r;
        if (rsv_r) begin
          res_status = STAT_NOT_HELD;
          res_count  = RCNT_RSV;
        end else if (mode_r == MODE_ADDREF && cur_cnt == '0) begin
          res_status = STAT_NOT_HELD;
        end else if (cur_cnt == COUNT_MAX) begin
          res_status = STAT_SATURATED;
          res_count  = {1'b0, COUNT_MAX};
        end else begin
          wr_en     = 1'b1;
          held_set  = 1'b1;
          res_count = {1'b0, alu_out};
        end
      end
      MODE_RELEASE: begin
        res_index = idx_r;
        if (rsv_r) begin
          res_status = STAT_NOT_HELD;
          res_count  = RCNT_RSV;
        end else if (cur_cnt == '0) begin
          res_status = STAT_NOT_HELD;
        end else begin
          wr_en     = 1'b1;
          held_clr  = (alu_out == '0);
          res_freed = (alu_out == '0);
          res_count = {1'b0, alu_out};
        end
      end
      MODE_QUERY: begin
        res_index = idx_r;
        res_count = rsv_r ? RCNT_RSV : {1'b0, cur_cnt};
      end
      MODE_FIND: begin
        if (hit_r) begin
          res_index = idx_r;
          res_found = 1'b1;
          res_count = {1'b0, cur_cnt};
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rsv_mask_r  <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        rsv_mask_r <= cfg_wdata;
      end
      if (commit && held_set) begin
        held_r[idx_r] <= 1'b1;
      end else if (commit && held_clr) begin
        held_r[idx_r] <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= in_mode;
      idx_r      <= sel_idx;
      hit_r      <= sel_hit;
      rsv_r      <= rsv_mask_r[sel_idx];
      held_bit_r <= held_r[sel_idx];
    end
  end

  // Count memory: registered read at accept, write-back on commit
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= cnt_mem[sel_idx];
    end
    if (commit && wr_en) begin
      cnt_mem[idx_r] <= wr_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_index_r  <= res_index;
      out_found_r  <= res_found;
      out_freed_r  <= res_freed;
      out_count_r  <= res_count;
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.reg_index   = out_index_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.became_free = out_freed_r;
  assign out_ch.ref_count   = $signed(out_count_r);
  assign out_ch.status      = out_status_r;

endmodule
